[design/page_bitmap_allocator_defines.svh]
// assertion macros for the page bitmap allocator
// included by page_bitmap_allocator, which carries concurrent checks; needs no other file
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define PBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// next-cycle implication, disabled during reset
`define PBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`else

`define PBA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[design/pba_pkg.sv]
// shared types and constants of the page bitmap allocator
// used by pba_word_unit, pba_map_ram and page_bitmap_allocator; no dependencies
package pba_pkg;

    localparam int ADDR_W     = 32;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int COUNT_W    = 12;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - ADDR_W - 1 - COUNT_W;

    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h0010_0000;

    // request into the shared map word unit
    typedef struct packed {
        logic [WORD_W-1:0] word;     // map word as read
        logic [WORD_W-1:0] pad;      // bits past the last page, treated as used
        logic              clear_op; // 1 test and clear bit_pos, 0 find lowest free
        logic [BIT_W-1:0]  bit_pos;  // bit to free
    } t_unit_req;

    // answer of the shared map word unit
    typedef struct packed {
        logic              hit;      // free bit found, or freed bit was used
        logic [BIT_W-1:0]  bit_pos;  // bit found or freed
        logic [WORD_W-1:0] word;     // word to write back
    } t_unit_res;

endpackage

[design/pba_map_ram.sv]
// used map storage: one write port, one read port with registered data
// depends on pba_pkg for the word width
module pba_map_ram #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [IDX_W-1:0]          i_wr_addr,
    input  logic [pba_pkg::WORD_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [IDX_W-1:0]          i_rd_addr,
    output logic [pba_pkg::WORD_W-1:0] o_rd_data
);
    import pba_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/pba_word_unit.sv]
// shared map word unit: lowest free bit search and set, or bit test and clear
// depends on pba_pkg for the request and answer structs
module pba_word_unit (
    input  pba_pkg::t_unit_req i_req,
    output pba_pkg::t_unit_res o_res
);
    import pba_pkg::*;

    logic [WORD_W-1:0] w_masked;
    logic [BIT_W-1:0]  w_free_pos;
    logic              w_free_any;
    logic [BIT_W-1:0]  w_pos;
    logic [WORD_W-1:0] w_onehot;

    // priority encoder for the lowest zero bit
    always_comb begin
        w_masked   = i_req.word | i_req.pad;
        w_free_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w_masked[i]) begin
                w_free_pos = BIT_W'(i);
            end
        end
        w_free_any = ~&w_masked;
    end

    // select the bit of interest and build the updated word
    always_comb begin
        w_pos    = i_req.clear_op ? i_req.bit_pos : w_free_pos;
        w_onehot = WORD_W'(1) << w_pos;
        o_res.bit_pos = w_pos;
        if (i_req.clear_op) begin
            o_res.hit  = i_req.word[w_pos];
            o_res.word = i_req.word & ~w_onehot;
        end else begin
            o_res.hit  = w_free_any;
            o_res.word = i_req.word | w_onehot;
        end
    end

endmodule

[design/page_bitmap_allocator.sv]
// page_bitmap_allocator: first-fit page allocator over a one-bit-per-page map
// depends on pba_pkg, pba_map_ram, pba_word_unit and page_bitmap_allocator_defines.svh
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           tuser mode, tdata release_address
//  m_axis    out  tvalid / tready           tdata page_address, granted, pages_in_use
//  cfg       in   i_cfg_wr_en               i_cfg_wr_data region_base
//
// allocate: the scan reads one 32-bit map word per cycle through the map ram's single
//   read port and stops at the first word with a free page, or after the last word
// release: the map word is read in S_REL_RD and its bit tested and cleared in S_REL_CHK;
//   an address out of range skips the read and goes straight to S_DONE
// after reset a clearing pass writes zero to every map word before s_axis_tready
// one request is in work at a time; a finished result waits in the output register and
//   the next request is taken meanwhile; a new result waits for that register to empty
`include "page_bitmap_allocator_defines.svh"

module page_bitmap_allocator #(
    parameter int PAGE_COUNT = 2048,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: region_base
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] release_address
    input  logic        s_axis_tuser,  // [0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [31:0] page_address, [32] granted,
                                       // [44:33] pages_in_use, [47:45] zero
);
    import pba_pkg::*;

    localparam int MAP_WORDS  = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);
    localparam int LAST_BITS  = PAGE_COUNT - (MAP_WORDS - 1) * WORD_W;
    localparam logic [63:0] LAST_ONES = (64'd1 << LAST_BITS) - 64'd1;
    localparam logic [WORD_W-1:0] PAD_MASK = ~LAST_ONES[WORD_W-1:0];
    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);
    localparam logic [WORD_IDX_W:0]   WORD_END  = (WORD_IDX_W + 1)'(MAP_WORDS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_REL_RD,
        S_REL_CHK,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_base;
    logic [COUNT_W-1:0]      r_count;
    logic [WORD_IDX_W:0]     r_issue;
    logic [WORD_IDX_W-1:0]   r_chk;
    logic                    r_chk_vld;
    logic                    r_rel_ok;
    logic [WORD_IDX_W-1:0]   r_rel_word;
    logic [BIT_W-1:0]        r_rel_bit;
    logic [PAGE_IDX_W-1:0]   r_page_idx;
    logic                    r_res_grant;
    logic                    r_res_alloc;
    logic                    r_out_valid;
    logic [ADDR_W-1:0]       r_out_addr;
    logic                    r_out_grant;
    logic [COUNT_W-1:0]      r_out_count;

    logic                    w_accept;
    logic [ADDR_W-1:0]       w_rel_idx;
    logic                    w_rd_en;
    logic [WORD_IDX_W-1:0]   w_rd_addr;
    logic                    w_wr_en;
    logic [WORD_IDX_W-1:0]   w_wr_addr;
    logic [WORD_W-1:0]       w_wr_data;
    logic [WORD_W-1:0]       w_rd_data;
    logic                    w_out_load;
    logic [ADDR_W-1:0]       w_alloc_addr;
    t_unit_req               u_req;
    t_unit_res               u_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // release index: offset from the region base, page bits dropped
    assign w_rel_idx = (s_axis_tdata - r_base) >> PAGE_SHIFT;

    // allocated address, taken modulo 2^32
    assign w_alloc_addr = r_base + (ADDR_W'(r_page_idx) << PAGE_SHIFT);

    // map ram read and write controls
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_issue[WORD_IDX_W-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_issue[WORD_IDX_W-1:0];
        w_wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                w_wr_en = 1'b1;
            end
            S_ALLOC: begin
                w_rd_en   = (r_issue < WORD_END);
                w_wr_en   = r_chk_vld && u_res.hit;
                w_wr_addr = r_chk;
                w_wr_data = u_res.word;
            end
            S_REL_RD: begin
                w_rd_en   = r_rel_ok;
                w_rd_addr = r_rel_word;
            end
            S_REL_CHK: begin
                w_wr_en   = u_res.hit;
                w_wr_addr = r_rel_word;
                w_wr_data = u_res.word;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // shared word unit input
    always_comb begin
        u_req.word     = w_rd_data;
        u_req.pad      = (r_state == S_ALLOC && r_chk == LAST_WORD) ? PAD_MASK : '0;
        u_req.clear_op = (r_state != S_ALLOC);
        u_req.bit_pos  = r_rel_bit;
    end

    pba_map_ram #(
        .DEPTH (MAP_WORDS),
        .IDX_W (WORD_IDX_W)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pba_word_unit u_word_unit (
        .i_req (u_req),
        .o_res (u_res)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= REGION_BASE_RST;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    // sequencer, in-use count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_issue     <= '0;
            r_chk_vld   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load a finished result, or empty it on a transaction
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_issue <= r_issue + 1'b1;
                    if (r_issue[WORD_IDX_W-1:0] == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_issue     <= '0;
                        r_chk_vld   <= 1'b0;
                        r_res_grant <= 1'b0;
                        r_res_alloc <= !s_axis_tuser;
                        r_rel_ok    <= (w_rel_idx < ADDR_W'(PAGE_COUNT));
                        r_rel_word  <= WORD_IDX_W'(w_rel_idx >> BIT_W);
                        r_rel_bit   <= w_rel_idx[BIT_W-1:0];
                        r_state     <= s_axis_tuser ? S_REL_RD : S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    // issue the next word while the previous one is checked
                    r_issue   <= r_issue + 1'b1;
                    r_chk     <= r_issue[WORD_IDX_W-1:0];
                    r_chk_vld <= w_rd_en;
                    if (r_chk_vld && u_res.hit) begin
                        r_page_idx  <= PAGE_IDX_W'({r_chk, u_res.bit_pos});
                        r_res_grant <= 1'b1;
                        r_count     <= r_count + COUNT_W'(1);
                        r_state     <= S_DONE;
                    end else if (r_chk_vld && r_chk == LAST_WORD) begin
                        // map full
                        r_state <= S_DONE;
                    end
                end
                S_REL_RD: begin
                    r_state <= r_rel_ok ? S_REL_CHK : S_DONE;
                end
                S_REL_CHK: begin
                    if (u_res.hit) begin
                        r_res_grant <= 1'b1;
                        r_count     <= r_count - COUNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_addr  <= (r_res_alloc && r_res_grant) ? w_alloc_addr : '0;
                        r_out_grant <= r_res_grant;
                        r_out_count <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_count, r_out_grant, r_out_addr};

    // checks
    `PBA_ASSERT_IMP(a_count_step, i_clk, i_rst_n, r_count != $past(r_count), (r_count == $past(r_count) + COUNT_W'(1)) || (r_count == $past(r_count) - COUNT_W'(1)))
    `PBA_ASSERT_IMP(a_write_state, i_clk, i_rst_n, w_wr_en, (r_state == S_CLEAR) || (r_state == S_ALLOC) || (r_state == S_REL_CHK))
    `PBA_ASSERT_IMP(a_chk_range, i_clk, i_rst_n, (r_state == S_ALLOC) && r_chk_vld, r_chk <= LAST_WORD)
    `PBA_ASSERT_IMP(a_out_free, i_clk, i_rst_n, w_out_load, !r_out_valid || m_axis_tready)
    `PBA_ASSERT_NEXT(a_rel_miss, i_clk, i_rst_n, (r_state == S_REL_CHK) && !u_res.hit, $stable(r_count))

endmodule

[tb/pba_checker.sv]
// request modes shared by the stimulus and the checker, and the result checker itself
// the checker tracks the page map and compares every result; needs pba_pkg
`timescale 1ns / 100ps

package pba_tb_pkg;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req_mode;

endpackage

module pba_checker #(
    parameter int PAGE_COUNT = 2048,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [31:0] i_req_tdata,   // [31:0] release_address
    input  logic        i_req_tuser,   // [0] mode
    input  logic        i_res_tvalid,
    input  logic        i_res_tready,
    input  logic [47:0] i_res_tdata,   // [31:0] page_address, [32] granted,
                                       // [44:33] pages_in_use
    output int          o_fail_count,
    output int          o_pending
);
    import pba_pkg::*;
    import pba_tb_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]  page_address;
        logic               granted;
        logic [COUNT_W-1:0] pages_in_use;
    } t_page_answer;

    // mirror of the allocator state
    logic [PAGE_COUNT-1:0] map_mirror;
    logic [COUNT_W-1:0]    pages_held;
    logic [ADDR_W-1:0]     base_addr;
    t_page_answer          due_answers[$];
    int                    bad_answers = 0;

    assign o_fail_count = bad_answers;

    task automatic flag_bad_answer(input string why, input t_page_answer want,
                                   input t_page_answer got);
        bad_answers++;
        if (bad_answers <= 10) begin
            $display("%0t: %s: expected addr %08h grant %0d count %0d,",
                     $realtime, why, want.page_address, want.granted, want.pages_in_use);
            $display("    got addr %08h grant %0d count %0d",
                     got.page_address, got.granted, got.pages_in_use);
        end
    endtask

    always @(posedge i_clk) begin : track
        logic [31:0]  slot;
        t_page_answer want;
        t_page_answer got;
        if (!i_rst_n) begin
            map_mirror = '0;
            pages_held = '0;
            base_addr  = REGION_BASE_RST;
            due_answers.delete();
        end else begin
            if (i_cfg_wr_en) begin
                base_addr = i_cfg_wr_data;
            end

            // result transaction: compare with the oldest prediction
            if (i_res_tvalid && i_res_tready) begin
                got.page_address = i_res_tdata[31:0];
                got.granted      = i_res_tdata[32];
                got.pages_in_use = i_res_tdata[44:33];
                if (due_answers.size() == 0) begin
                    flag_bad_answer("result with no request pending", '0, got);
                end else begin
                    want = due_answers.pop_front();
                    if (got.page_address !== want.page_address ||
                        got.granted !== want.granted ||
                        got.pages_in_use !== want.pages_in_use) begin
                        flag_bad_answer("result mismatch", want, got);
                    end
                end
            end

            // request transaction: predict the answer
            if (i_req_tvalid && i_req_tready) begin
                want = '0;
                if (i_req_tuser == REQ_ALLOC) begin
                    // first fit over the page map
                    slot = 0;
                    while (slot < PAGE_COUNT && map_mirror[slot]) begin
                        slot++;
                    end
                    if (slot < PAGE_COUNT) begin
                        map_mirror[slot]  = 1'b1;
                        pages_held        = pages_held + 1'b1;
                        want.page_address = base_addr + (slot << PAGE_SHIFT);
                        want.granted      = 1'b1;
                    end
                end else begin
                    // offset from base wraps, page offset bits drop out
                    slot = (i_req_tdata - base_addr) >> PAGE_SHIFT;
                    if (slot < PAGE_COUNT && map_mirror[slot]) begin
                        map_mirror[slot] = 1'b0;
                        pages_held       = pages_held - 1'b1;
                        want.granted     = 1'b1;
                    end
                end
                want.pages_in_use = pages_held;
                due_answers.push_back(want);
            end
        end
        o_pending <= due_answers.size();
    end

endmodule

[tb/tb_top.sv]
// top of the page allocator testbench: clock, reset, request stimulus and verdict
// instantiates page_bitmap_allocator and pba_checker; needs pba_pkg and pba_tb_pkg
`timescale 1ns / 100ps

module tb_top;
    import pba_pkg::*;
    import pba_tb_pkg::*;

    localparam int PAGES = 2048;
    localparam int SHIFT = 12;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // [31:0] release_address
    logic        s_axis_tuser  = 1'b0; // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [31:0] page_address, [32] granted,
                                      // [44:33] pages_in_use, [47:45] zero
    logic        calm          = 1'b0;
    logic [31:0] cur_base      = REGION_BASE_RST;
    int          fail_count;
    int          pending;

    always #4 i_clk = ~i_clk;

    page_bitmap_allocator #(
        .PAGE_COUNT(PAGES),
        .PAGE_SHIFT(SHIFT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    pba_checker #(
        .PAGE_COUNT(PAGES),
        .PAGE_SHIFT(SHIFT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_req_tuser  (s_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 38);
    end

    // one request transaction, with random idle cycles ahead of it unless calm is set
    task automatic send_request(input t_req_mode mode, input logic [31:0] addr);
        while (!calm && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // drain all results, then move the region base
    task automatic set_region_base(input logic [31:0] base);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= base;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_base = base;
    endtask

    // random mix of allocations and releases; releases mostly aim at pages up to max_page,
    // the rest are stray addresses below the base, past the map or fully random
    task automatic run_mixed(input int count, input int release_pct, input int max_page);
        logic [31:0] addr;
        logic [31:0] page;
        int          pick;
        repeat (count) begin
            addr = $urandom();
            if ($urandom_range(99) < release_pct) begin
                pick = $urandom_range(99);
                page = $urandom_range(0, max_page);
                if (pick < 75) begin
                    addr = cur_base + (page << SHIFT);
                    if ($urandom_range(1)) begin
                        addr = addr + $urandom_range(0, (1 << SHIFT) - 1);
                    end
                end else if (pick < 85) begin
                    addr = cur_base - $urandom_range(1, 2 << SHIFT);
                end else if (pick < 92) begin
                    addr = cur_base + (PAGES << SHIFT) + $urandom_range(0, 1 << 20);
                end
                send_request(REQ_RELEASE, addr);
            end else begin
                send_request(REQ_ALLOC, addr);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first fit, releases in and out of range
        set_region_base(REGION_BASE_RST);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_RELEASE, cur_base + (1 << SHIFT) + 32'hABC);   // inside a page
        send_request(REQ_RELEASE, cur_base + (1 << SHIFT));             // already free
        send_request(REQ_RELEASE, cur_base - (1 << SHIFT));             // below base
        send_request(REQ_RELEASE, cur_base + (PAGES << SHIFT));         // past the map
        send_request(REQ_RELEASE, cur_base + ((PAGES - 1) << SHIFT));   // last page, free
        send_request(REQ_RELEASE, 32'h0000_0000);
        send_request(REQ_RELEASE, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_RELEASE, cur_base);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_RELEASE, cur_base + (3 << SHIFT) - 1);

        // base near the top of the address space, addresses wrap
        set_region_base(32'hFFFF_F000);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_RELEASE, 32'h0000_0FFF);
        send_request(REQ_RELEASE, 32'hFFFF_F000);
        send_request(REQ_RELEASE, 32'h0000_1000);

        // random traffic around low pages, first without any idling
        set_region_base(32'h0000_0000);
        calm <= 1'b1;
        run_mixed(150, 45, 47);
        calm <= 1'b0;
        run_mixed(200, 50, 47);

        // unaligned base at the very top; mostly allocations to reach deeper map words
        set_region_base(32'hFFFF_FFFF);
        run_mixed(250, 20, PAGES - 1);

        // random page aligned base
        set_region_base($urandom() & ~((32'd1 << SHIFT) - 1));
        run_mixed(180, 55, PAGES - 1);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/pba_pkg.sv
design/pba_map_ram.sv
design/pba_word_unit.sv
design/page_bitmap_allocator.sv
tb/pba_checker.sv
tb/tb_top.sv
